### design/rtnh_pkg.sv
`default_nettype none
package rtnh_pkg;

  localparam int unsigned COORD_WIDTH_DEF   = 32;
  localparam int unsigned FRAC_BITS_DEF     = 16;
  localparam int unsigned MATERIAL_BITS_DEF = 16;

  // normals and edge cross products are clamped to this many signed bits
  localparam int unsigned INNER_BITS = 60;

  // shared multiplier operand, product and accumulator widths
  localparam int unsigned OW        = 64;
  localparam int unsigned PW        = 2 * OW;
  localparam int unsigned AW        = PW + 2;
  localparam int unsigned MUL_DIGIT = 4;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;

  typedef logic signed [OW-1:0] op_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [AW-1:0] acc_t;

  typedef struct packed {
    logic start;
    op_t  a;
    op_t  b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    prod_t p;
  } mul_rsp_t;

  function automatic op_t sat_inner(acc_t v);
    acc_t mx;
    acc_t mn;
    mx = (acc_t'(1) <<< (INNER_BITS - 1)) - acc_t'(1);
    mn = -mx - acc_t'(1);
    if (v > mx) sat_inner = op_t'(mx);
    else if (v < mn) sat_inner = op_t'(mn);
    else sat_inner = op_t'(v);
  endfunction

endpackage
`default_nettype wire

### design/rtnh_ifs.sv
`default_nettype none
interface rtnh_tri_if #(
  parameter int unsigned CW = rtnh_pkg::COORD_WIDTH_DEF,
  parameter int unsigned MB = rtnh_pkg::MATERIAL_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] a_x, a_y, a_z;
  logic signed [CW-1:0] b_x, b_y, b_z;
  logic signed [CW-1:0] c_x, c_y, c_z;
  logic [MB-1:0]        in_material;
  logic                 last;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  in_material, last, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                in_material, last, output ready);
endinterface

interface rtnh_res_if #(
  parameter int unsigned CW = rtnh_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FB = rtnh_pkg::FRAC_BITS_DEF,
  parameter int unsigned MB = rtnh_pkg::MATERIAL_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [FB:0]          hit_t;
  logic signed [CW-1:0] hit_x, hit_y, hit_z;
  logic signed [CW-1:0] normal_x, normal_y, normal_z;
  logic [MB-1:0]        hit_material;

  modport source (output valid, hit, hit_t, hit_x, hit_y, hit_z, normal_x, normal_y,
                  normal_z, hit_material, input ready);
  modport sink (input valid, hit, hit_t, hit_x, hit_y, hit_z, normal_x, normal_y,
                normal_z, hit_material, output ready);
endinterface
`default_nettype wire

### design/rtnh_mul.sv
`default_nettype none
// Signed multiplier, magnitude times magnitude, MUL_DIGIT bits of b per cycle.
module rtnh_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtnh_pkg::mul_req_t req_i,
  output rtnh_pkg::mul_rsp_t rsp_o
);

  localparam int unsigned STEPS = rtnh_pkg::OW / rtnh_pkg::MUL_DIGIT;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam int unsigned PPW   = rtnh_pkg::OW + rtnh_pkg::MUL_DIGIT;

  logic [rtnh_pkg::OW-1:0] ma_q, mb_q, ua, ub;
  logic                    neg_q, busy_q, done_q;
  logic [rtnh_pkg::PW-1:0] acc_q, acc_d;
  logic [PPW-1:0]          pp;
  logic [CNT_W-1:0]        cnt_q;
  rtnh_pkg::prod_t         p_q;

  assign ua = req_i.a[rtnh_pkg::OW-1] ? rtnh_pkg::OW'(-req_i.a) : rtnh_pkg::OW'(req_i.a);
  assign ub = req_i.b[rtnh_pkg::OW-1] ? rtnh_pkg::OW'(-req_i.b) : rtnh_pkg::OW'(req_i.b);
  assign pp = PPW'(ma_q) * PPW'(mb_q[rtnh_pkg::OW-1 -: rtnh_pkg::MUL_DIGIT]);
  assign acc_d = (acc_q << rtnh_pkg::MUL_DIGIT) + rtnh_pkg::PW'(pp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (req_i.start) begin
        ma_q  <= ua;
        mb_q  <= ub;
        neg_q <= req_i.a[rtnh_pkg::OW-1] ^ req_i.b[rtnh_pkg::OW-1];
        acc_q <= '0;
      end
    end else begin
      acc_q <= acc_d;
      mb_q  <= mb_q << rtnh_pkg::MUL_DIGIT;
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        p_q <= neg_q ? -rtnh_pkg::prod_t'(acc_d) : rtnh_pkg::prod_t'(acc_d);
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = p_q;

endmodule
`default_nettype wire

### design/rtnh_front.sv
`default_nettype none
// Takes triangles, forms edge and origin-offset vectors, holds them in a two-entry queue.
module rtnh_front #(
  parameter int unsigned CW = rtnh_pkg::COORD_WIDTH_DEF,
  parameter int unsigned MB = rtnh_pkg::MATERIAL_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rtnh_tri_if.sink             tri_i,
  input  logic signed [CW-1:0] org_i [3],
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output logic signed [CW-1:0] vert_o [9],
  output logic signed [CW:0]   edge_o [12],
  output logic [MB-1:0]        mat_o,
  output logic                 last_o
);

  logic signed [CW-1:0] in_v [9];
  logic signed [CW:0]   in_e [12];
  logic signed [CW-1:0] v_q [2][9];
  logic signed [CW:0]   e_q [2][12];
  logic [MB-1:0]        m_q [2];
  logic                 l_q [2];
  logic                 wp_q, rp_q;
  logic [1:0]           cnt_q;
  logic                 push, pop;

  assign in_v[0] = tri_i.a_x;
  assign in_v[1] = tri_i.a_y;
  assign in_v[2] = tri_i.a_z;
  assign in_v[3] = tri_i.b_x;
  assign in_v[4] = tri_i.b_y;
  assign in_v[5] = tri_i.b_z;
  assign in_v[6] = tri_i.c_x;
  assign in_v[7] = tri_i.c_y;
  assign in_v[8] = tri_i.c_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_e[k]     = (CW+1)'(in_v[3+k]) - (CW+1)'(in_v[k]);
      in_e[3+k]   = (CW+1)'(in_v[6+k]) - (CW+1)'(in_v[3+k]);
      in_e[6+k]   = (CW+1)'(in_v[k])   - (CW+1)'(in_v[6+k]);
      in_e[9+k]   = (CW+1)'(in_v[k])   - (CW+1)'(org_i[k]);
    end
  end

  assign tri_i.ready = (cnt_q != 2'd2);
  assign push        = tri_i.valid && tri_i.ready;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign pop         = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      v_q[wp_q] <= in_v;
      e_q[wp_q] <= in_e;
      m_q[wp_q] <= tri_i.in_material;
      l_q[wp_q] <= tri_i.last;
    end
  end

  assign vert_o = v_q[rp_q];
  assign edge_o = e_q[rp_q];
  assign mat_o  = m_q[rp_q];
  assign last_o = l_q[rp_q];

endmodule
`default_nettype wire

### design/rtnh_back.sv
`default_nettype none
// Runs the intersection test for the queue head on the shared multiplier and keeps the
// nearest hit.
module rtnh_back #(
  parameter int unsigned CW = rtnh_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FB = rtnh_pkg::FRAC_BITS_DEF,
  parameter int unsigned MB = rtnh_pkg::MATERIAL_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic signed [CW-1:0] org_i [3],
  input  logic signed [CW-1:0] dir_i [3],
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  logic signed [CW-1:0] vert_i [9],
  input  logic signed [CW:0]   edge_i [12],
  input  logic [MB-1:0]        mat_i,
  input  logic                 last_i,
  output rtnh_pkg::mul_req_t   mul_req_o,
  input  rtnh_pkg::mul_rsp_t   mul_rsp_i,
  rtnh_res_if.source           res_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CROSS = 3'd1;
  localparam logic [2:0] ST_DOT   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_PT    = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  localparam logic [2:0] PS_NORM  = 3'd0;
  localparam logic [2:0] PS_DEN   = 3'd1;
  localparam logic [2:0] PS_NUM   = 3'd2;
  localparam logic [2:0] PS_XEDGE = 3'd3;
  localparam logic [2:0] PS_XDOT  = 3'd4;

  localparam int unsigned DW = $clog2(FB + 1);

  typedef rtnh_pkg::op_t  op_t;
  typedef rtnh_pkg::acc_t acc_t;

  logic [2:0]    st_q, pass_q, cnt_q;
  logic [1:0]    e_q;
  logic [DW-1:0] dcnt_q;
  logic          wait_q, ok_q;

  op_t  cu_q [3], cv_q [3], n_q [3], cx_q [3], p_q [3];
  acc_t acc_q, dd_q, r_q;
  logic [FB:0] tq_q;

  logic                 found_q;
  logic [FB:0]          best_t_q;
  logic signed [CW-1:0] bp_q [3], bn_q [3];
  logic [MB-1:0]        bm_q;

  logic                 ov_q, hit_q;
  logic [FB:0]          ot_q;
  logic signed [CW-1:0] op_q [3], on_q [3];
  logic [MB-1:0]        om_q;

  logic [1:0] ij, ik, ti;
  op_t        opa, opb;
  acc_t       pe, crs_sum, dot_sum, neg_sum, rs;
  op_t        cross_sat;
  logic       ge;
  logic [FB:0] tq_n;
  op_t        vsel [3], esel [3], dext [3], oext [3], aoext [3];
  logic       emit_ok;

  function automatic logic signed [CW-1:0] sat_c(op_t v);
    op_t mx;
    op_t mn;
    mx = (op_t'(1) <<< (CW - 1)) - op_t'(1);
    mn = -mx - op_t'(1);
    if (v > mx) sat_c = CW'(mx);
    else if (v < mn) sat_c = CW'(mn);
    else sat_c = CW'(v);
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dext[k]  = op_t'(dir_i[k]);
      oext[k]  = op_t'(org_i[k]);
      aoext[k] = op_t'(edge_i[9+k]);
    end
    for (int k = 0; k < 3; k++) begin
      unique case (e_q)
        2'd0: begin
          vsel[k] = op_t'(vert_i[k]);
          esel[k] = op_t'(edge_i[k]);
        end
        2'd1: begin
          vsel[k] = op_t'(vert_i[3+k]);
          esel[k] = op_t'(edge_i[3+k]);
        end
        default: begin
          vsel[k] = op_t'(vert_i[6+k]);
          esel[k] = op_t'(edge_i[6+k]);
        end
      endcase
    end
  end

  // operand selection for the term in flight
  always_comb begin
    unique case (cnt_q[2:1])
      2'd0: begin
        ij = 2'd1;
        ik = 2'd2;
      end
      2'd1: begin
        ij = 2'd2;
        ik = 2'd0;
      end
      default: begin
        ij = 2'd0;
        ik = 2'd1;
      end
    endcase
    ti  = cnt_q[1:0];
    opa = '0;
    opb = '0;
    unique case (st_q)
      ST_CROSS: begin
        opa = cnt_q[0] ? cu_q[ik] : cu_q[ij];
        opb = cnt_q[0] ? cv_q[ij] : cv_q[ik];
      end
      ST_DOT: begin
        unique case (pass_q)
          PS_DEN: begin
            opa = dext[ti];
            opb = n_q[ti];
          end
          PS_NUM: begin
            opa = n_q[ti];
            opb = aoext[ti];
          end
          default: begin
            opa = cx_q[ti];
            opb = n_q[ti];
          end
        endcase
      end
      ST_PT: begin
        opa = op_t'({1'b0, tq_q});
        opb = dext[ti];
      end
      default: ;
    endcase
  end

  assign mul_req_o.start = !wait_q && (st_q == ST_CROSS || st_q == ST_DOT || st_q == ST_PT);
  assign mul_req_o.a     = opa;
  assign mul_req_o.b     = opb;

  assign pe        = acc_t'(mul_rsp_i.p);
  assign crs_sum   = cnt_q[0] ? acc_q - pe : pe;
  assign cross_sat = rtnh_pkg::sat_inner(crs_sum >>> FB);
  assign dot_sum   = (cnt_q[1:0] == 2'd0) ? pe : acc_q + pe;
  assign neg_sum   = -dot_sum;

  assign rs   = (dcnt_q == '0) ? r_q : (r_q <<< 1);
  assign ge   = (rs >= dd_q);
  assign tq_n = (dcnt_q == '0) ? (FB+1)'(ge) : {tq_q[FB-1:0], ge};

  assign emit_ok   = !ov_q || res_o.ready;
  assign q_ready_o = (st_q == ST_FIN && !last_i) || (st_q == ST_EMIT && emit_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      pass_q   <= PS_NORM;
      cnt_q    <= '0;
      e_q      <= '0;
      dcnt_q   <= '0;
      wait_q   <= 1'b0;
      ok_q     <= 1'b0;
      found_q  <= 1'b0;
      best_t_q <= (FB+1)'(1) << FB;
      bp_q     <= '{default: '0};
      bn_q     <= '{default: '0};
      bm_q     <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (ov_q && res_o.ready) ov_q <= 1'b0;
      if (mul_req_o.start) wait_q <= 1'b1;
      unique case (st_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            st_q   <= ST_CROSS;
            pass_q <= PS_NORM;
            cnt_q  <= '0;
            ok_q   <= 1'b0;
          end
        end
        ST_CROSS: begin
          if (mul_rsp_i.done) begin
            wait_q <= 1'b0;
            cnt_q  <= cnt_q + 3'd1;
            if (cnt_q == 3'd5) begin
              cnt_q  <= '0;
              st_q   <= ST_DOT;
              pass_q <= (pass_q == PS_NORM) ? PS_DEN : PS_XDOT;
            end
          end
        end
        ST_DOT: begin
          if (mul_rsp_i.done) begin
            wait_q <= 1'b0;
            cnt_q  <= cnt_q + 3'd1;
            if (cnt_q == 3'd2) begin
              cnt_q <= '0;
              unique case (pass_q)
                PS_DEN: begin
                  // faces away, or degenerate
                  if (!dot_sum[rtnh_pkg::AW-1]) st_q <= ST_FIN;
                  else pass_q <= PS_NUM;
                end
                PS_NUM: begin
                  if (neg_sum[rtnh_pkg::AW-1] || neg_sum > dd_q) st_q <= ST_FIN;
                  else begin
                    st_q   <= ST_DIV;
                    dcnt_q <= '0;
                  end
                end
                default: begin
                  if (dot_sum[rtnh_pkg::AW-1]) st_q <= ST_FIN;
                  else if (e_q == 2'd2) begin
                    ok_q <= 1'b1;
                    st_q <= ST_FIN;
                  end else begin
                    e_q  <= e_q + 2'd1;
                    st_q <= ST_LOAD;
                  end
                end
              endcase
            end
          end
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q + DW'(1);
          if (dcnt_q == DW'(FB)) begin
            if (tq_n > best_t_q) st_q <= ST_FIN;
            else begin
              st_q  <= ST_PT;
              cnt_q <= '0;
            end
          end
        end
        ST_PT: begin
          if (mul_rsp_i.done) begin
            wait_q <= 1'b0;
            cnt_q  <= cnt_q + 3'd1;
            if (cnt_q == 3'd2) begin
              cnt_q <= '0;
              e_q   <= '0;
              st_q  <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          st_q   <= ST_CROSS;
          pass_q <= PS_XEDGE;
          cnt_q  <= '0;
        end
        ST_FIN: begin
          if (ok_q) begin
            found_q  <= 1'b1;
            best_t_q <= tq_q;
            bm_q     <= mat_i;
            for (int k = 0; k < 3; k++) begin
              bp_q[k] <= sat_c(p_q[k]);
              bn_q[k] <= sat_c(n_q[k]);
            end
          end
          st_q <= last_i ? ST_EMIT : ST_IDLE;
        end
        default: begin
          if (emit_ok) begin
            ov_q     <= 1'b1;
            found_q  <= 1'b0;
            best_t_q <= (FB+1)'(1) << FB;
            bp_q     <= '{default: '0};
            bn_q     <= '{default: '0};
            bm_q     <= '0;
            st_q     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        for (int k = 0; k < 3; k++) begin
          cu_q[k] <= op_t'(edge_i[k]);
          cv_q[k] <= op_t'(edge_i[3+k]);
        end
      end
      ST_CROSS: begin
        if (mul_rsp_i.done) begin
          acc_q <= crs_sum;
          if (cnt_q[0]) begin
            cx_q[cnt_q[2:1]] <= cross_sat;
            if (pass_q == PS_NORM) n_q[cnt_q[2:1]] <= cross_sat;
          end
        end
      end
      ST_DOT: begin
        if (mul_rsp_i.done) begin
          acc_q <= dot_sum;
          if (cnt_q == 3'd2) begin
            if (pass_q == PS_DEN) dd_q <= neg_sum;
            r_q <= neg_sum;
          end
        end
      end
      ST_DIV: begin
        r_q  <= ge ? rs - dd_q : rs;
        tq_q <= tq_n;
      end
      ST_PT: begin
        if (mul_rsp_i.done) p_q[ti] <= oext[ti] + op_t'(mul_rsp_i.p >>> FB);
      end
      ST_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          cu_q[k] <= vsel[k] - p_q[k];
          cv_q[k] <= esel[k];
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          hit_q <= found_q;
          ot_q  <= best_t_q;
          op_q  <= bp_q;
          on_q  <= bn_q;
          om_q  <= bm_q;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid        = ov_q;
  assign res_o.hit          = hit_q;
  assign res_o.hit_t        = ot_q;
  assign res_o.hit_x        = op_q[0];
  assign res_o.hit_y        = op_q[1];
  assign res_o.hit_z        = op_q[2];
  assign res_o.normal_x     = on_q[0];
  assign res_o.normal_y     = on_q[1];
  assign res_o.normal_z     = on_q[2];
  assign res_o.hit_material = om_q;

endmodule
`default_nettype wire

### design/ray_triangle_nearest_hit_core.sv
// Nearest ray-triangle hit over a stream of triangles.
// The ray is set through the write port: cfg_idx_i 0..2 origin x/y/z, 3..5 direction
// (end minus start) x/y/z, signed fixed point; other indexes are ignored. Write only
// while the block is idle.
// tri_i takes one triangle per request: three vertices, a material and a last flag.
// res_o gives one request per query, after the triangle marked last: hit flag, t as a
// fraction of the ray, hit point, raw face normal and material of the nearest hit.
// Each triangle runs through one shared multiplier that retires 4 operand bits a cycle.
// A triangle rejected at the facing test stops after the normal and the facing dot
// product; one that passes every test takes 42 products plus a restoring divide for
// the FRAC_BITS+1 bits of t. One triangle is in work at a time; a two-entry queue
// takes the next triangles meanwhile.
// After a last triangle's work, its result goes through the finish and emit states.
// Reset clears the ray to zero and the kept hit to none; no clearing pass.
// If res_o stalls, the result holds in its output register; the next query's triangles
// are still worked on, and a further result waits until the previous one is taken.
`default_nettype none
module ray_triangle_nearest_hit_core #(
  parameter int unsigned COORD_WIDTH   = rtnh_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS     = rtnh_pkg::FRAC_BITS_DEF,
  parameter int unsigned MATERIAL_BITS = rtnh_pkg::MATERIAL_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rtnh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]           cfg_data_i,
  rtnh_tri_if.sink                         tri_i,
  rtnh_res_if.source                       res_o
);

  logic signed [COORD_WIDTH-1:0] org_q [3], dir_q [3];
  logic signed [COORD_WIDTH-1:0] vert [9];
  logic signed [COORD_WIDTH:0]   edges [12];
  logic [MATERIAL_BITS-1:0]      mat;
  logic                          last, q_valid, q_ready;
  rtnh_pkg::mul_req_t            mul_req;
  rtnh_pkg::mul_rsp_t            mul_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q <= '{default: '0};
      dir_q <= '{default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rtnh_pkg::CFG_ORIGIN_X: org_q[0] <= cfg_data_i;
        rtnh_pkg::CFG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        rtnh_pkg::CFG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        rtnh_pkg::CFG_DIR_X:    dir_q[0] <= cfg_data_i;
        rtnh_pkg::CFG_DIR_Y:    dir_q[1] <= cfg_data_i;
        rtnh_pkg::CFG_DIR_Z:    dir_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rtnh_front #(.CW(COORD_WIDTH), .MB(MATERIAL_BITS)) u_front (
    .clk_i, .rst_ni, .tri_i, .org_i(org_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready),
    .vert_o(vert), .edge_o(edges), .mat_o(mat), .last_o(last)
  );

  rtnh_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));

  rtnh_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS), .MB(MATERIAL_BITS)) u_back (
    .clk_i, .rst_ni, .org_i(org_q), .dir_i(dir_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready),
    .vert_i(vert), .edge_i(edges), .mat_i(mat), .last_i(last),
    .mul_req_o(mul_req), .mul_rsp_i(mul_rsp), .res_o
  );

endmodule
`default_nettype wire

### design/rtnh_chk.sv
`default_nettype none
module rtnh_chk #(
  parameter int unsigned FB = rtnh_pkg::FRAC_BITS_DEF,
  parameter int unsigned MB = rtnh_pkg::MATERIAL_BITS_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic          hit_i,
  input logic [FB:0]   hit_t_i,
  input logic [MB-1:0] hit_material_i
);

  localparam logic [FB:0] T_FULL = (FB+1)'(1) << FB;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_miss_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_i |-> hit_t_i == T_FULL)
    else $error("miss without full ray t");

  a_miss_mat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_i |-> hit_material_i == '0)
    else $error("miss with nonzero material");

  a_hit_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> hit_t_i <= T_FULL)
    else $error("hit t beyond ray end");

endmodule

bind ray_triangle_nearest_hit_core rtnh_chk #(.FB(FRAC_BITS), .MB(MATERIAL_BITS)) u_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .hit_i(res_o.hit),
  .hit_t_i(res_o.hit_t),
  .hit_material_i(res_o.hit_material)
);
`default_nettype wire
